FILE: rtl/bps_pkg.sv
package bps_pkg;

  localparam int unsigned RegW   = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PAT_SINGLE = 2'd0,
    PAT_TRIPLE = 2'd1,
    PAT_IDLE   = 2'd2
  } pat_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAIN_TONE     = 4'd0,
    REG_IDLE_TONE     = 4'd1,
    REG_SINGLE_ON     = 4'd2,
    REG_SINGLE_PAUSE  = 4'd3,
    REG_TRIPLE_ON     = 4'd4,
    REG_TRIPLE_PAUSE  = 4'd5,
    REG_IDLE_ON       = 4'd6,
    REG_IDLE_PAUSE    = 4'd7
  } reg_idx_e;

  localparam logic [RegW-1:0] RstMainTone    = 16'd2000;
  localparam logic [RegW-1:0] RstIdleTone    = 16'd1500;
  localparam logic [RegW-1:0] RstSingleOn    = 16'd50;
  localparam logic [RegW-1:0] RstSinglePause = 16'd100;
  localparam logic [RegW-1:0] RstTripleOn    = 16'd40;
  localparam logic [RegW-1:0] RstTriplePause = 16'd80;
  localparam logic [RegW-1:0] RstIdleOn      = 16'd30;
  localparam logic [RegW-1:0] RstIdlePause   = 16'd60;

  localparam logic [1:0] BeepsSingle = 2'd1;
  localparam logic [1:0] BeepsIdle   = 2'd2;
  localparam logic [1:0] BeepsTriple = 2'd3;

endpackage

FILE: rtl/beep_pattern_sequencer.sv
// result: a request's result is registered and presented in the cycle after it is accepted
// throughput: one request per cycle, set by the single state update per request
// the input stalls only while a held result is stalled, results go back to back
// reset: asynchronous active low, sequencer goes idle with the tone off,
// registers return to their default timings and tones
module beep_pattern_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bps_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bps_pkg::RegW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [1:0]                     pattern_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           tone_on_o,
  output logic [bps_pkg::RegW-1:0]       tone_freq_o,
  output logic                           busy_res_o,
  output logic                           done_flag_o
);

  // configuration registers
  logic [bps_pkg::RegW-1:0] main_tone_q, idle_tone_q, single_on_q, single_pause_q;
  logic [bps_pkg::RegW-1:0] triple_on_q, triple_pause_q, idle_on_q, idle_pause_q;

  // sequencer state
  logic                     running_q, running_d;
  logic                     done_q, done_d;
  logic                     in_pause_q, in_pause_d;
  logic [1:0]               cur_pattern_q, cur_pattern_d;
  logic [1:0]               beeps_left_q, beeps_left_d;
  logic [bps_pkg::RegW-1:0] elapsed_q, elapsed_d;
  logic [bps_pkg::RegW-1:0] cur_on_q, cur_on_d;
  logic [bps_pkg::RegW-1:0] cur_pause_q, cur_pause_d;
  logic                     sounding_q, sounding_d;
  logic [bps_pkg::RegW-1:0] cur_freq_q, cur_freq_d;

  // result register
  logic                     out_valid_q;
  logic                     tone_on_q;
  logic [bps_pkg::RegW-1:0] tone_freq_q;
  logic                     busy_q;
  logic                     flag_q;
  logic                     flag_d;

  logic                     accept;
  logic [bps_pkg::RegW-1:0] elapsed_inc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign elapsed_inc = (elapsed_q == {bps_pkg::RegW{1'b1}}) ? elapsed_q
                                                             : elapsed_q + 1'b1;

  always_comb begin
    running_d     = running_q;
    done_d        = done_q;
    in_pause_d    = in_pause_q;
    cur_pattern_d = cur_pattern_q;
    beeps_left_d  = beeps_left_q;
    elapsed_d     = elapsed_q;
    cur_on_d      = cur_on_q;
    cur_pause_d   = cur_pause_q;
    sounding_d    = sounding_q;
    cur_freq_d    = cur_freq_q;
    flag_d        = done_q;

    if (accept) begin
      case (command_i)
        bps_pkg::CMD_TICK: begin
          if (running_q) begin
            elapsed_d = elapsed_inc;
            if (!in_pause_q) begin
              if (elapsed_inc >= cur_on_q) begin
                sounding_d = 1'b0;
                elapsed_d  = '0;
                if (beeps_left_q > 2'd1) begin
                  beeps_left_d = beeps_left_q - 2'd1;
                  in_pause_d   = 1'b1;
                end else begin
                  running_d = 1'b0;
                  done_d    = 1'b1;
                end
              end
            end else if (elapsed_inc >= cur_pause_q) begin
              in_pause_d = 1'b0;
              elapsed_d  = '0;
              if (cur_pattern_q == bps_pkg::PAT_IDLE && beeps_left_q == 2'd1) begin
                cur_on_d = single_on_q;
              end
              cur_freq_d = main_tone_q;
              sounding_d = 1'b1;
            end
          end
        end
        bps_pkg::CMD_START: begin
          if (!running_q) begin
            done_d        = 1'b0;
            running_d     = 1'b1;
            cur_pattern_d = pattern_i;
            in_pause_d    = 1'b0;
            elapsed_d     = '0;
            sounding_d    = 1'b1;
            case (pattern_i)
              bps_pkg::PAT_TRIPLE: begin
                beeps_left_d = bps_pkg::BeepsTriple;
                cur_on_d     = triple_on_q;
                cur_pause_d  = triple_pause_q;
                cur_freq_d   = main_tone_q;
              end
              bps_pkg::PAT_IDLE: begin
                beeps_left_d = bps_pkg::BeepsIdle;
                cur_on_d     = idle_on_q;
                cur_pause_d  = idle_pause_q;
                cur_freq_d   = idle_tone_q;
              end
              default: begin
                beeps_left_d = bps_pkg::BeepsSingle;
                cur_on_d     = single_on_q;
                cur_pause_d  = single_pause_q;
                cur_freq_d   = main_tone_q;
              end
            endcase
          end
        end
        bps_pkg::CMD_STOP: begin
          sounding_d    = 1'b0;
          running_d     = 1'b0;
          done_d        = 1'b0;
          cur_pattern_d = bps_pkg::PAT_SINGLE;
          in_pause_d    = 1'b0;
          elapsed_d     = '0;
        end
        default: begin
          done_d = 1'b0;
        end
      endcase
      flag_d = (command_i == bps_pkg::CMD_ACK) ? done_q : done_d;
    end

    // main tone write also retunes the current tone
    if (cfg_we_i && cfg_idx_i == bps_pkg::REG_MAIN_TONE) begin
      cur_freq_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_tone_q    <= bps_pkg::RstMainTone;
      idle_tone_q    <= bps_pkg::RstIdleTone;
      single_on_q    <= bps_pkg::RstSingleOn;
      single_pause_q <= bps_pkg::RstSinglePause;
      triple_on_q    <= bps_pkg::RstTripleOn;
      triple_pause_q <= bps_pkg::RstTriplePause;
      idle_on_q      <= bps_pkg::RstIdleOn;
      idle_pause_q   <= bps_pkg::RstIdlePause;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bps_pkg::REG_MAIN_TONE:    main_tone_q    <= cfg_wdata_i;
        bps_pkg::REG_IDLE_TONE:    idle_tone_q    <= cfg_wdata_i;
        bps_pkg::REG_SINGLE_ON:    single_on_q    <= cfg_wdata_i;
        bps_pkg::REG_SINGLE_PAUSE: single_pause_q <= cfg_wdata_i;
        bps_pkg::REG_TRIPLE_ON:    triple_on_q    <= cfg_wdata_i;
        bps_pkg::REG_TRIPLE_PAUSE: triple_pause_q <= cfg_wdata_i;
        bps_pkg::REG_IDLE_ON:      idle_on_q      <= cfg_wdata_i;
        bps_pkg::REG_IDLE_PAUSE:   idle_pause_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q     <= 1'b0;
      done_q        <= 1'b0;
      in_pause_q    <= 1'b0;
      cur_pattern_q <= bps_pkg::PAT_SINGLE;
      beeps_left_q  <= '0;
      elapsed_q     <= '0;
      cur_on_q      <= '0;
      cur_pause_q   <= '0;
      sounding_q    <= 1'b0;
      cur_freq_q    <= bps_pkg::RstMainTone;
    end else begin
      running_q     <= running_d;
      done_q        <= done_d;
      in_pause_q    <= in_pause_d;
      cur_pattern_q <= cur_pattern_d;
      beeps_left_q  <= beeps_left_d;
      elapsed_q     <= elapsed_d;
      cur_on_q      <= cur_on_d;
      cur_pause_q   <= cur_pause_d;
      sounding_q    <= sounding_d;
      cur_freq_q    <= cur_freq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tone_on_q   <= sounding_d;
      tone_freq_q <= cur_freq_d;
      busy_q      <= running_d;
      flag_q      <= flag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tone_on_o   = tone_on_q;
  assign tone_freq_o = tone_freq_q;
  assign busy_res_o  = busy_q;
  assign done_flag_o = flag_q;

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> in_stall_o)
    else $error("request taken while result register is held");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

  a_tone_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sounding_q |-> running_q)
    else $error("tone on while sequencer idle");

  a_pause_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pause_q |-> running_q && !sounding_q)
    else $error("pause phase with tone on or sequencer idle");

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import bps_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam logic [1:0] PatUnused = 2'd3;

  typedef struct packed {
    logic            tone_on;
    logic [RegW-1:0] tone_freq;
    logic            busy;
    logic            done_flag;
  } chirp_t;

  typedef struct {
    cmd_e       cmd;
    logic [1:0] pat;
    bit         zero_cfg;
    bit         known;
    chirp_t     want;
  } dir_row_t;

  typedef enum {SET_SHORT, SET_MIXED, SET_FULL, SET_ZERO} setting_e;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [1:0]      command_i = CMD_TICK;
  logic [1:0]      pattern_i = PAT_SINGLE;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            tone_on_o;
  logic [RegW-1:0] tone_freq_o;
  logic            busy_res_o;
  logic            done_flag_o;

  beep_pattern_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .pattern_i   (pattern_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tone_on_o   (tone_on_o),
    .tone_freq_o (tone_freq_o),
    .busy_res_o  (busy_res_o),
    .done_flag_o (done_flag_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sequencer shadow state
  logic [RegW-1:0] timing_regs [NumRegs];
  logic            seq_running;
  logic            seq_done;
  logic            in_gap;
  pat_e            active_pat;
  logic [1:0]      beeps_remaining;
  logic [RegW-1:0] phase_ms;
  logic [RegW-1:0] on_len;
  logic [RegW-1:0] gap_len;
  logic            tone_active;
  logic [RegW-1:0] tone_hz;

  chirp_t      chirp_q [$];
  bit          row_known = 1'b0;
  chirp_t      row_want = '0;
  bit          calm = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  dir_row_t directed_rows [22] = '{
    '{CMD_TICK,  PAT_SINGLE, 1'b0, 1'b1, '{1'b0, RstMainTone, 1'b0, 1'b0}},
    '{CMD_ACK,   PAT_TRIPLE, 1'b0, 1'b1, '{1'b0, RstMainTone, 1'b0, 1'b0}},
    '{CMD_STOP,  PAT_IDLE,   1'b0, 1'b1, '{1'b0, RstMainTone, 1'b0, 1'b0}},
    '{CMD_START, PAT_SINGLE, 1'b0, 1'b1, '{1'b1, RstMainTone, 1'b1, 1'b0}},
    // start while running is dropped
    '{CMD_START, PAT_TRIPLE, 1'b0, 1'b1, '{1'b1, RstMainTone, 1'b1, 1'b0}},
    '{CMD_TICK,  PAT_SINGLE, 1'b0, 1'b0, '0},
    '{CMD_STOP,  PAT_SINGLE, 1'b0, 1'b1, '{1'b0, RstMainTone, 1'b0, 1'b0}},
    '{CMD_START, PatUnused,  1'b0, 1'b1, '{1'b1, RstMainTone, 1'b1, 1'b0}},
    '{CMD_STOP,  PatUnused,  1'b0, 1'b1, '{1'b0, RstMainTone, 1'b0, 1'b0}},
    '{CMD_START, PAT_IDLE,   1'b0, 1'b1, '{1'b1, RstIdleTone, 1'b1, 1'b0}},
    '{CMD_TICK,  PAT_IDLE,   1'b0, 1'b0, '0},
    // stop keeps the tone frequency
    '{CMD_STOP,  PAT_SINGLE, 1'b0, 1'b1, '{1'b0, RstIdleTone, 1'b0, 1'b0}},
    '{CMD_START, PAT_TRIPLE, 1'b0, 1'b1, '{1'b1, RstMainTone, 1'b1, 1'b0}},
    '{CMD_TICK,  PAT_TRIPLE, 1'b0, 1'b0, '0},
    '{CMD_ACK,   PAT_SINGLE, 1'b0, 1'b1, '{1'b1, RstMainTone, 1'b1, 1'b0}},
    '{CMD_STOP,  PAT_TRIPLE, 1'b0, 1'b1, '{1'b0, RstMainTone, 1'b0, 1'b0}},
    // zero length phases end on the first tick
    '{CMD_START, PAT_IDLE,   1'b1, 1'b1, '{1'b1, 16'd0, 1'b1, 1'b0}},
    '{CMD_TICK,  PAT_SINGLE, 1'b0, 1'b0, '0},
    '{CMD_TICK,  PAT_TRIPLE, 1'b0, 1'b0, '0},
    '{CMD_TICK,  PatUnused,  1'b0, 1'b0, '0},
    '{CMD_ACK,   PAT_SINGLE, 1'b0, 1'b1, '{1'b0, 16'd0, 1'b0, 1'b1}},
    '{CMD_ACK,   PAT_IDLE,   1'b0, 1'b1, '{1'b0, 16'd0, 1'b0, 1'b0}}
  };

  function automatic chirp_t advance_sequencer(input logic [1:0] cmd, input logic [1:0] pat);
    chirp_t res;
    case (cmd)
      CMD_TICK: begin
        if (seq_running) begin
          if (phase_ms != '1) phase_ms = phase_ms + 1'b1;
          if (!in_gap) begin
            if (phase_ms >= on_len) begin
              tone_active = 1'b0;
              phase_ms = '0;
              if (beeps_remaining > BeepsSingle) begin
                beeps_remaining = beeps_remaining - 1'b1;
                in_gap = 1'b1;
              end else begin
                seq_running = 1'b0;
                seq_done = 1'b1;
              end
            end
          end else if (phase_ms >= gap_len) begin
            in_gap = 1'b0;
            phase_ms = '0;
            if (active_pat == PAT_IDLE && beeps_remaining == BeepsSingle) begin
              on_len = timing_regs[REG_SINGLE_ON];
            end
            tone_hz = timing_regs[REG_MAIN_TONE];
            tone_active = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (!seq_running) begin
          seq_done = 1'b0;
          seq_running = 1'b1;
          in_gap = 1'b0;
          phase_ms = '0;
          tone_active = 1'b1;
          tone_hz = timing_regs[REG_MAIN_TONE];
          case (pat)
            PAT_TRIPLE: begin
              active_pat = PAT_TRIPLE;
              beeps_remaining = BeepsTriple;
              on_len = timing_regs[REG_TRIPLE_ON];
              gap_len = timing_regs[REG_TRIPLE_PAUSE];
            end
            PAT_IDLE: begin
              active_pat = PAT_IDLE;
              beeps_remaining = BeepsIdle;
              on_len = timing_regs[REG_IDLE_ON];
              gap_len = timing_regs[REG_IDLE_PAUSE];
              tone_hz = timing_regs[REG_IDLE_TONE];
            end
            default: begin
              active_pat = PAT_SINGLE;
              beeps_remaining = BeepsSingle;
              on_len = timing_regs[REG_SINGLE_ON];
              gap_len = timing_regs[REG_SINGLE_PAUSE];
            end
          endcase
        end
      end
      CMD_STOP: begin
        tone_active = 1'b0;
        seq_running = 1'b0;
        seq_done = 1'b0;
        active_pat = PAT_SINGLE;
        in_gap = 1'b0;
        phase_ms = '0;
      end
      default: ;
    endcase
    res = '{tone_active, tone_hz, seq_running, seq_done};
    if (cmd == CMD_ACK) seq_done = 1'b0;
    return res;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fault_count++;
      $display("%0t %s expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    chirp_t exp_chirp;
    chirp_t pred;
    if (!rst_ni) begin
      timing_regs = '{RstMainTone, RstIdleTone, RstSingleOn, RstSinglePause,
                      RstTripleOn, RstTriplePause, RstIdleOn, RstIdlePause};
      seq_running = 1'b0;
      seq_done = 1'b0;
      in_gap = 1'b0;
      active_pat = PAT_SINGLE;
      beeps_remaining = '0;
      phase_ms = '0;
      on_len = '0;
      gap_len = '0;
      tone_active = 1'b0;
      tone_hz = RstMainTone;
      hold_cycles = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (chirp_q.size() == 0) begin
          fault_count++;
          $display("%0t unexpected result expected none actual %0d/%0d/%0d/%0d", $time,
                   tone_on_o, tone_freq_o, busy_res_o, done_flag_o);
        end else begin
          exp_chirp = chirp_q.pop_front();
          check_field("tone_on", exp_chirp.tone_on, tone_on_o);
          check_field("tone_freq", exp_chirp.tone_freq, tone_freq_o);
          check_field("busy_res", exp_chirp.busy, busy_res_o);
          check_field("done_flag", exp_chirp.done_flag, done_flag_o);
        end
        hold_cycles = calm ? 0 : $urandom_range(0, 7);
      end else if (out_valid_o && hold_cycles != 0) begin
        hold_cycles--;
      end
      if (cfg_we_i && cfg_idx_i < NumRegs) begin
        timing_regs[cfg_idx_i] = cfg_wdata_i;
        if (cfg_idx_i == REG_MAIN_TONE) tone_hz = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        pred = advance_sequencer(command_i, pattern_i);
        chirp_q.push_back(row_known ? row_want : pred);
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_cycles != 0);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input cmd_e cmd, input logic [1:0] pat, input bit known,
                              input chirp_t want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    command_i = cmd;
    pattern_i = pat;
    row_known = known;
    row_want = want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (chirp_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_timings(input setting_e s);
    logic [RegW-1:0] v;
    for (int i = 0; i < NumRegs; i++) begin
      case (s)
        SET_ZERO: v = '0;
        SET_FULL: v = '1;
        SET_MIXED: begin
          case ($urandom_range(0, 3))
            0: v = '0;
            1: v = 16'd1;
            2: v = '1;
            default: v = 16'($urandom_range(0, 4));
          endcase
        end
        default: v = (i <= REG_IDLE_TONE) ? 16'($urandom) : 16'($urandom_range(0, 6));
      endcase
      write_reg(CfgIdxW'(i), v);
    end
    // unmapped index, must be ignored
    if (s == SET_MIXED) begin
      write_reg(CfgIdxW'(NumRegs + $urandom_range(0, 15 - NumRegs)), 16'($urandom));
    end
  endtask

  task automatic run_random(input setting_e s, input int target);
    int   counted;
    int   roll;
    cmd_e cmd;
    wait_drained();
    load_timings(s);
    counted = 0;
    while (counted < target) begin
      roll = $urandom_range(0, 99);
      if (!seq_running) begin
        cmd = roll < 55 ? CMD_START : roll < 75 ? CMD_TICK : roll < 90 ? CMD_ACK : CMD_STOP;
      end else begin
        cmd = roll < 80 ? CMD_TICK : roll < 88 ? CMD_START : roll < 94 ? CMD_STOP : CMD_ACK;
      end
      send_request(cmd, 2'($urandom_range(0, 3)), 1'b0, '0);
      counted++;
      if (counted == target / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].zero_cfg) begin
        wait_drained();
        load_timings(SET_ZERO);
      end
      send_request(directed_rows[i].cmd, directed_rows[i].pat, directed_rows[i].known,
                   directed_rows[i].want);
    end

    run_random(SET_SHORT, 260);
    run_random(SET_MIXED, 260);
    run_random(SET_FULL, 120);
    run_random(SET_ZERO, 120);
    calm = 1'b1;
    run_random(SET_SHORT, 260);
    calm = 1'b0;
    run_random(SET_SHORT, 260);

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bps_pkg.sv
rtl/beep_pattern_sequencer.sv
tb/tb_top.sv
